### rtl/timed_key_discard_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed key discard table
// Concurrent checks sampled on the rising clock edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_KEY_DISCARD_TABLE_ASSERT_SVH
`define TIMED_KEY_DISCARD_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKDT_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("timed key discard table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TKDT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("timed key discard table: next-cycle check failed");

`endif

### rtl/tkdt_pkg.sv
// ----------------------------------------------------------------------------
// tkdt_pkg
// Command codes, status codes and shared types of the timed key discard table.
// ----------------------------------------------------------------------------
package tkdt_pkg;

  typedef enum logic [2:0] {
    CMD_TRACK    = 3'd0,
    CMD_MARK     = 3'd1,
    CMD_CLEAR    = 3'd2,
    CMD_KEEP     = 3'd3,
    CMD_DISCARD  = 3'd4,
    CMD_PURGE    = 3'd5,
    CMD_TICK     = 3'd6
  } cmd_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int PURGE_BITS = 7;
  localparam logic [PURGE_BITS-1:0] PURGE_MAX = '1;

  // Per-entry decisions taken on one word read from the table.
  typedef struct packed {
    logic match;
    logic vacant;
    logic expired;
    logic drop;
  } eval_t;

endpackage

### rtl/tkdt_eval.sv
// ----------------------------------------------------------------------------
// tkdt_eval
// Classifies one table word: key hit, free slot, expiry and purge decision.
// ----------------------------------------------------------------------------
module tkdt_eval #(
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                 valid,
  input  logic                 received,
  input  logic                 has_exp,
  input  logic [TIME_BITS-1:0] exp_time,
  input  logic [KEY_BITS-1:0]  entry_key,
  input  logic [KEY_BITS-1:0]  ref_key,
  input  logic [TIME_BITS-1:0] now,
  output tkdt_pkg::eval_t      flags
);
  import tkdt_pkg::*;

  logic expired;

  assign expired       = (exp_time <= now);
  assign flags.match   = valid && (entry_key == ref_key);
  assign flags.vacant  = !valid;
  assign flags.expired = expired;
  // An entry with an expiry goes when it runs out, one without when unreceived.
  assign flags.drop    = valid && (has_exp ? expired : !received);

endmodule

### rtl/timed_key_discard_table.sv
// ----------------------------------------------------------------------------
// timed_key_discard_table
// Key table with time-to-live expiry, received flags, queries and purge.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Words carry
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | one command word: command, key, flags, window
//  out_    | master    | one result word per command: keep, discard,
//          |           | status, purged_count
//
// A tick, an unused code or a command refused by its flags goes from acceptance
// through the done state straight to the output register. A purge walks the
// whole table through the single read port (one read per slot, one evaluation
// behind it) and then passes the done state; the lookups add an update state.
// After reset a clearing pass writes every slot, so in_tready stays low until
// the pass is through. A result waiting in the output register lets the next
// word in; a second finished result then waits for out_tready.
//
`include "timed_key_discard_table_assert.svh"

module timed_key_discard_table #(
  parameter int ENTRIES   = 64,
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata from bit 0 up: key[63:0], has_issue, has_rule, has_window,
  // window_ticks[31:0], five zero bits.
  input  logic [103:0] in_tdata,
  // in_tuser: command[2:0].
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata from bit 0 up: keep, discard, status[1:0], purged_count[6:0],
  // five zero bits.
  output logic [15:0]  out_tdata
);
  import tkdt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  // Width that holds the time plus a full window without wrapping.
  localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  typedef struct packed {
    logic                 valid;
    logic                 received;
    logic                 has_exp;
    logic [TIME_BITS-1:0] exp_time;
    logic [KEY_BITS-1:0]  key;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Input word fields.
  logic [63:0] in_key;
  logic        in_has_issue;
  logic        in_has_rule;
  logic        in_has_window;
  logic [31:0] in_window;
  logic        in_fire;

  assign in_key        = in_tdata[63:0];
  assign in_has_issue  = in_tdata[64];
  assign in_has_rule   = in_tdata[65];
  assign in_has_window = in_tdata[66];
  assign in_window     = in_tdata[98:67];

  state_t               state_r, state_nxt;
  logic [AW-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [AW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]        free_idx_r, free_idx_nxt;
  entry_t               hit_word_r, hit_word_nxt;
  logic                 hit_exp_r, hit_exp_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic                 has_window_r, has_window_nxt;
  logic [31:0]          win_r, win_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [PURGE_BITS-1:0] purge_cnt_r, purge_cnt_nxt;

  // Result waiting for the output register.
  logic                  res_keep_r, res_keep_nxt;
  logic                  res_discard_r, res_discard_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [PURGE_BITS-1:0] res_purged_r, res_purged_nxt;

  // Output register.
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  out_keep_r, out_keep_nxt;
  logic                  out_discard_r, out_discard_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [PURGE_BITS-1:0] out_purged_r, out_purged_nxt;

  // Entry memory, one read and one write port.
  entry_t        mem [ENTRIES];
  entry_t        mem_q_r;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  eval_t                 ev;
  logic [PURGE_BITS-1:0] cnt_inc;
  logic [SW-1:0]         exp_sum;
  logic [TIME_BITS-1:0]  exp_new;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_purged_r, out_status_r, out_discard_r, out_keep_r};

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[scan_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  tkdt_eval #(
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .valid     (mem_q_r.valid),
    .received  (mem_q_r.received),
    .has_exp   (mem_q_r.has_exp),
    .exp_time  (mem_q_r.exp_time),
    .entry_key (mem_q_r.key),
    .ref_key   (key_r),
    .now       (time_r),
    .flags     (ev)
  );

  // Saturating purge counter step for the word under evaluation.
  assign cnt_inc = (ev.drop && (purge_cnt_r != PURGE_MAX)) ?
                   purge_cnt_r + PURGE_BITS'(1) : purge_cnt_r;

  // Expiry of a new entry: current time plus window, held at the time maximum.
  assign exp_sum = SW'(time_r) + SW'(win_r);
  assign exp_new = (exp_sum > SW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} :
                   exp_sum[TIME_BITS-1:0];

  always_comb begin
    state_nxt       = state_r;
    scan_cnt_nxt    = scan_cnt_r;
    issue_done_nxt  = issue_done_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    free_found_nxt  = free_found_r;
    hit_idx_nxt     = hit_idx_r;
    free_idx_nxt    = free_idx_r;
    hit_word_nxt    = hit_word_r;
    hit_exp_nxt     = hit_exp_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    has_window_nxt  = has_window_r;
    win_nxt         = win_r;
    time_nxt        = time_r;
    purge_cnt_nxt   = purge_cnt_r;
    res_keep_nxt    = res_keep_r;
    res_discard_nxt = res_discard_r;
    res_status_nxt  = res_status_r;
    res_purged_nxt  = res_purged_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_keep_nxt    = out_keep_r;
    out_discard_nxt = out_discard_r;
    out_status_nxt  = out_status_r;
    out_purged_nxt  = out_purged_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = scan_cnt_r;
    mem_wd          = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // Clearing pass: every slot is written empty once after reset.
        mem_we = 1'b1;
        if (scan_cnt_r == LAST_IDX) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt         = cmd_t'(in_tuser);
          key_nxt         = in_key[KEY_BITS-1:0];
          has_window_nxt  = in_has_window;
          win_nxt         = in_window;
          scan_cnt_nxt    = '0;
          issue_done_nxt  = 1'b0;
          found_nxt       = 1'b0;
          free_found_nxt  = 1'b0;
          purge_cnt_nxt   = '0;
          res_keep_nxt    = 1'b0;
          res_discard_nxt = 1'b0;
          res_status_nxt  = STAT_OK;
          res_purged_nxt  = '0;
          state_nxt       = ST_SCAN;
          unique case (cmd_t'(in_tuser)) inside
            CMD_TRACK: begin
              if (!in_has_issue || !in_has_rule) begin
                res_status_nxt = STAT_MISS;
                state_nxt      = ST_DONE;
              end
            end
            CMD_MARK, CMD_CLEAR: begin
              if (!in_has_issue) begin
                res_status_nxt = STAT_MISS;
                state_nxt      = ST_DONE;
              end
            end
            CMD_KEEP: begin
              if (!in_has_issue) begin
                res_status_nxt = STAT_MISS;
                state_nxt      = ST_DONE;
              end else if (!in_has_rule) begin
                // Issue not managed by a rule: always kept.
                res_keep_nxt   = 1'b1;
                res_status_nxt = STAT_MISS;
                state_nxt      = ST_DONE;
              end
            end
            CMD_DISCARD, CMD_PURGE: begin
              state_nxt = ST_SCAN;
            end
            CMD_TICK: begin
              if (time_r != {TIME_BITS{1'b1}}) begin
                time_nxt = time_r + TIME_BITS'(1);
              end
              state_nxt = ST_DONE;
            end
            default: begin
              res_status_nxt = STAT_MISS;
              state_nxt      = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Read slot scan_cnt_r while evaluating the slot whose word is registered in mem_q_r.
        if (!issue_done_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_cnt_r;
          if (scan_cnt_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_cnt_nxt = scan_cnt_r + AW'(1);
          end
        end
        if (rd_vld_r) begin
          if (cmd_r == CMD_PURGE) begin
            // Write back at the evaluated slot; the read is one slot ahead.
            if (ev.drop) begin
              mem_we       = 1'b1;
              mem_wa       = rd_idx_r;
              mem_wd       = mem_q_r;
              mem_wd.valid = 1'b0;
            end
            purge_cnt_nxt = cnt_inc;
          end else begin
            if (ev.match && !found_r) begin
              found_nxt    = 1'b1;
              hit_idx_nxt  = rd_idx_r;
              hit_word_nxt = mem_q_r;
              hit_exp_nxt  = ev.expired;
            end
            if (ev.vacant && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = rd_idx_r;
            end
          end
          if (rd_idx_r == LAST_IDX) begin
            if (cmd_r == CMD_PURGE) begin
              res_purged_nxt = cnt_inc;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end

      ST_FIN: begin
        state_nxt = ST_DONE;
        case (cmd_r) inside
          CMD_TRACK: begin
            if (found_r) begin
              mem_we          = 1'b1;
              mem_wa          = hit_idx_r;
              mem_wd          = hit_word_r;
              mem_wd.received = 1'b1;
              mem_wd.has_exp  = has_window_r && hit_word_r.has_exp;
            end else if (free_found_r) begin
              mem_we          = 1'b1;
              mem_wa          = free_idx_r;
              mem_wd.valid    = 1'b1;
              mem_wd.received = 1'b1;
              mem_wd.has_exp  = has_window_r;
              mem_wd.exp_time = has_window_r ? exp_new : '0;
              mem_wd.key      = key_r;
            end else begin
              res_status_nxt = STAT_FULL;
            end
          end
          CMD_MARK, CMD_CLEAR: begin
            if (found_r) begin
              mem_we          = 1'b1;
              mem_wa          = hit_idx_r;
              mem_wd          = hit_word_r;
              mem_wd.received = (cmd_r == CMD_MARK);
            end else begin
              res_status_nxt = STAT_MISS;
            end
          end
          CMD_KEEP: begin
            if (found_r) begin
              res_keep_nxt = hit_word_r.has_exp ? !hit_exp_r : hit_word_r.received;
            end else begin
              res_status_nxt = STAT_MISS;
            end
          end
          CMD_DISCARD: begin
            if (found_r) begin
              res_discard_nxt = !hit_word_r.has_exp || !hit_exp_r;
            end else begin
              res_status_nxt = STAT_MISS;
            end
          end
          default: begin
            res_status_nxt = res_status_r;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_keep_nxt    = res_keep_r;
          out_discard_nxt = res_discard_r;
          out_status_nxt  = res_status_r;
          out_purged_nxt  = res_purged_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      scan_cnt_r   <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      time_r       <= '0;
      purge_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      time_r       <= time_nxt;
      purge_cnt_r  <= purge_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_idx_r    <= free_idx_nxt;
    hit_word_r    <= hit_word_nxt;
    hit_exp_r     <= hit_exp_nxt;
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    has_window_r  <= has_window_nxt;
    win_r         <= win_nxt;
    res_keep_r    <= res_keep_nxt;
    res_discard_r <= res_discard_nxt;
    res_status_r  <= res_status_nxt;
    res_purged_r  <= res_purged_nxt;
    out_keep_r    <= out_keep_nxt;
    out_discard_r <= out_discard_nxt;
    out_status_r  <= out_status_nxt;
    out_purged_r  <= out_purged_nxt;
  end

  // Only one word is in work at a time: acceptance closes the input.
  `TKDT_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_fire, !in_tready)
  // During the walk the table is written only by a purge.
  `TKDT_ASSERT_SAME(a_scan_write_purge, clk, rst_n,
                    mem_we && (state_r == ST_SCAN), cmd_r == CMD_PURGE)
  // A finished result that finds the output free is shown next cycle.
  `TKDT_ASSERT_NEXT(a_result_shown, clk, rst_n,
                    (state_r == ST_DONE) && (!out_tvalid_r || out_tready), out_tvalid)

endmodule
